// ===== sv/mbc3_pkg.sv =====
// Shared constants and types of the MBC3 bank controller.
`default_nettype none

package mbc3_pkg;

   // Geometry of the cartridge.
   localparam int RAM_BANKS_DEFAULT = 4;
   localparam int ROM_BANK_BYTES    = 16384;
   localparam int RAM_BANK_BYTES    = 8192;
   localparam int ROM_OFFSET_W      = $clog2(ROM_BANK_BYTES);
   localparam int RAM_OFFSET_W      = $clog2(RAM_BANK_BYTES);
   localparam int ROM_BANK_W        = 7;
   localparam int ROM_ADDR_W        = ROM_BANK_W + ROM_OFFSET_W;
   localparam int SELECT_W          = 4;

   // Result kinds.
   localparam logic [1:0] KIND_ROM     = 2'd0;
   localparam logic [1:0] KIND_READ    = 2'd1;
   localparam logic [1:0] KIND_WRITE   = 2'd2;
   localparam logic [1:0] KIND_INVALID = 2'd3;

   // Control register regions, taken from address bits 14 and 13.
   localparam logic [1:0] REGION_ENABLE   = 2'd0;
   localparam logic [1:0] REGION_ROM_BANK = 2'd1;
   localparam logic [1:0] REGION_RAM_SEL  = 2'd2;
   localparam logic [1:0] REGION_LATCH    = 2'd3;

   // Data patterns and select codes.
   localparam logic [3:0] ENABLE_PATTERN = 4'hA;
   localparam logic [7:0] LATCH_ARM      = 8'h00;
   localparam logic [7:0] LATCH_FIRE     = 8'h01;
   localparam logic [3:0] RTC_FIRST      = 4'h8;
   localparam logic [3:0] RTC_LAST       = 4'hC;
   localparam int         RTC_COUNT      = 5;
   localparam int         RTC_IDX_W      = $clog2(RTC_COUNT);

   // Write request from the decoder to the control registers.
   typedef struct packed {
      logic       ctrl_we;
      logic       rtc_we;
      logic [1:0] region;
      logic [7:0] data;
   } ctrl_wr_type;

   // Current control state seen by the decoder.
   typedef struct packed {
      logic                  ram_enable;
      logic [ROM_BANK_W-1:0] rom_page;
      logic [SELECT_W-1:0]   ram_select;
      logic                  latch_in;
      logic [7:0]            rtc_rd_data;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// ===== sv/mbc3_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
`default_nettype none

module mbc3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One optional write and one read per cycle, both at addr.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/mbc3_ctrl.sv =====
// Bank, enable and clock-latch registers plus the five RTC byte registers.
`default_nettype none

module mbc3_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mbc3_pkg::ctrl_wr_type wr,
   output mbc3_pkg::ctrl_stat_type    stat
);

   import mbc3_pkg::*;

   logic                  enable_ff,  enable_in;
   logic [ROM_BANK_W-1:0] rom_page_ff, rom_page_in;
   logic [SELECT_W-1:0]   ram_sel_ff, ram_sel_in;
   logic                  armed_ff,   armed_in;
   logic                  latch_ff,   latch_in;
   logic [7:0]            rtc_ff [RTC_COUNT];
   logic [SELECT_W-1:0]   rtc_offset;
   logic [RTC_IDX_W-1:0]  rtc_idx;
   logic                  rtc_hit;

   // The RTC register is chosen by the RAM/RTC select.
   assign rtc_offset = ram_sel_ff - RTC_FIRST;
   assign rtc_idx    = rtc_offset[RTC_IDX_W-1:0];
   assign rtc_hit    = (ram_sel_ff >= RTC_FIRST) && (ram_sel_ff <= RTC_LAST);

   // Next values of the control registers for a control write.
   always_comb begin
      enable_in   = enable_ff;
      rom_page_in = rom_page_ff;
      ram_sel_in  = ram_sel_ff;
      armed_in    = armed_ff;
      latch_in    = latch_ff;
      if (wr.ctrl_we) begin
         case (wr.region)
            REGION_ENABLE: begin
               enable_in = (wr.data[3:0] == ENABLE_PATTERN);
            end
            REGION_ROM_BANK: begin
               rom_page_in = (wr.data[ROM_BANK_W-1:0] == '0) ?
                             ROM_BANK_W'(1) : wr.data[ROM_BANK_W-1:0];
            end
            REGION_RAM_SEL: begin
               ram_sel_in = wr.data[SELECT_W-1:0];
            end
            REGION_LATCH: begin
               if (wr.data == LATCH_ARM) begin
                  armed_in = 1'b1;
               end else if ((wr.data == LATCH_FIRE) && armed_ff) begin
                  latch_in = ~latch_ff;
                  armed_in = 1'b0;
               end
            end
            default: begin
               enable_in = enable_ff;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b1;
         rom_page_ff <= ROM_BANK_W'(1);
         ram_sel_ff  <= '0;
         armed_ff    <= 1'b0;
         latch_ff    <= 1'b0;
      end else begin
         enable_ff   <= enable_in;
         rom_page_ff <= rom_page_in;
         ram_sel_ff  <= ram_sel_in;
         armed_ff    <= armed_in;
         latch_ff    <= latch_in;
      end
   end

   // RTC byte registers, plain storage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RTC_COUNT; i++) begin
            rtc_ff[i] <= '0;
         end
      end else if (wr.rtc_we && rtc_hit) begin
         rtc_ff[rtc_idx] <= wr.data;
      end
   end

   // Status towards the decoder.
   assign stat.ram_enable  = enable_ff;
   assign stat.rom_page    = rom_page_ff;
   assign stat.ram_select  = ram_sel_ff;
   assign stat.latch_in    = latch_in;
   assign stat.rtc_rd_data = rtc_hit ? rtc_ff[rtc_idx] : 8'h00;

endmodule

`default_nettype wire

// ===== sv/mbc3_bank_controller_top.sv =====
// Top level of the MBC3 bank controller: bus decode, cartridge RAM and result stage.
//
//   Channel   Ports                                   Handshake
//   request   req_op, req_bus_address, req_write_data  start, busy
//   result    rsp_result_kind, rsp_rom_address,        rsp_valid (one-cycle strobe)
//             rsp_read_data, rsp_clock_latched
//
// A request may be taken every cycle; busy stays low.
// The result appears in the cycle after the request is taken, as does the registered
// read of the cartridge RAM; control and RTC writes take effect at the accepting edge.
// Reset is synchronous; control and RTC registers return to their reset values,
// cartridge RAM contents are kept and undefined until written.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none

module mbc3_bank_controller_top #(
   parameter int RAM_BANKS = mbc3_pkg::RAM_BANKS_DEFAULT
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire logic [15:0]                   req_bus_address,
   input  wire logic [7:0]                    req_write_data,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_result_kind,
   output logic [mbc3_pkg::ROM_ADDR_W-1:0]    rsp_rom_address,
   output logic [7:0]                         rsp_read_data,
   output logic                               rsp_clock_latched
);

   import mbc3_pkg::*;

   localparam int RAM_DEPTH = RAM_BANKS * RAM_BANK_BYTES;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   logic                        accept;
   logic                        ctrl_region;
   logic                        window_region;
   logic                        ram_hit;
   logic                        rtc_hit;
   logic [SELECT_W+RAM_OFFSET_W-1:0] ram_idx_full;
   logic [RAM_AW-1:0]           ram_addr;
   logic                        ram_we;
   logic [7:0]                  ram_rd_data;
   ctrl_wr_type                 ctrl_wr;
   ctrl_stat_type               ctrl_stat;
   logic [1:0]                  kind_in;
   logic [ROM_ADDR_W-1:0]       rom_addr_in;
   logic [7:0]                  rdata_in;
   logic                        use_ram_in;

   logic                        valid_ff;
   logic [1:0]                  kind_ff;
   logic [ROM_ADDR_W-1:0]       rom_addr_ff;
   logic [7:0]                  rdata_ff;
   logic                        use_ram_ff;
   logic                        latch_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Address decode.
   assign ctrl_region   = !req_bus_address[15];
   assign window_region = (req_bus_address[15:13] == 3'b101);
   assign ram_hit       = ctrl_stat.ram_enable &&
                          (ctrl_stat.ram_select < SELECT_W'(RAM_BANKS));
   assign rtc_hit       = ctrl_stat.ram_enable &&
                          (ctrl_stat.ram_select >= RTC_FIRST) &&
                          (ctrl_stat.ram_select <= RTC_LAST);

   // Cartridge RAM index: bank select over the offset within the 8 KiB window.
   assign ram_idx_full = {ctrl_stat.ram_select, req_bus_address[RAM_OFFSET_W-1:0]};
   assign ram_addr     = ram_idx_full[RAM_AW-1:0];
   assign ram_we       = accept && req_op && window_region && ram_hit;

   // Write requests to the control and RTC registers.
   assign ctrl_wr.ctrl_we = accept && req_op && ctrl_region;
   assign ctrl_wr.rtc_we  = accept && req_op && window_region && rtc_hit;
   assign ctrl_wr.region  = req_bus_address[14:13];
   assign ctrl_wr.data    = req_write_data;

   mbc3_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .wr    (ctrl_wr),
      .stat  (ctrl_stat)
   );

   mbc3_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_save_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (req_write_data),
      .rd_data (ram_rd_data)
   );

   // Result of the request, apart from the RAM byte, which comes from the registered RAM read.
   always_comb begin
      kind_in     = KIND_INVALID;
      rom_addr_in = '0;
      rdata_in    = 8'h00;
      use_ram_in  = 1'b0;
      if (ctrl_region) begin
         if (req_op) begin
            kind_in = KIND_WRITE;
         end else begin
            kind_in = KIND_ROM;
            if (req_bus_address[ROM_OFFSET_W]) begin
               rom_addr_in = {ctrl_stat.rom_page, req_bus_address[ROM_OFFSET_W-1:0]};
            end else begin
               rom_addr_in = {{ROM_BANK_W{1'b0}}, req_bus_address[ROM_OFFSET_W-1:0]};
            end
         end
      end else if (window_region) begin
         if (req_op) begin
            kind_in = KIND_WRITE;
         end else begin
            kind_in    = KIND_READ;
            use_ram_in = ram_hit;
            rdata_in   = rtc_hit ? ctrl_stat.rtc_rd_data : 8'h00;
         end
      end
   end

   // Result stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff     <= kind_in;
         rom_addr_ff <= rom_addr_in;
         rdata_ff    <= rdata_in;
         use_ram_ff  <= use_ram_in;
         latch_ff    <= ctrl_stat.latch_in;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_rom_address   = rom_addr_ff;
   assign rsp_read_data     = use_ram_ff ? ram_rd_data : rdata_ff;
   assign rsp_clock_latched = latch_ff;

endmodule

`default_nettype wire

// ===== test/mbc3_bank_controller_top_tb.sv =====
// Self-checking testbench for the MBC3 bank controller: directed table, then random bus requests.
`timescale 1ns / 1ps

module mbc3_bank_controller_top_tb;
   import mbc3_pkg::*;

   // Bus access kinds as carried on req_op.
   localparam bit OP_READ  = 1'b0;
   localparam bit OP_WRITE = 1'b1;

   localparam int          RAM_BANKS      = RAM_BANKS_DEFAULT;
   localparam int          DIRECTED_COUNT = 26;
   localparam int          RANDOM_ITEMS   = 1750;
   localparam int          QUIET_TAIL     = 150;
   localparam int          DRAIN_CYCLES   = 4;
   localparam int unsigned CYCLE_LIMIT    = 200000;

   // One result of a bus access.
   typedef struct packed {
      logic [1:0]            kind;
      logic [ROM_ADDR_W-1:0] rom_addr;
      logic [7:0]            rd_data;
      logic                  latched;
   } bus_result_type;

   // One row of the directed table; the result is only used where typed is set.
   typedef struct {
      bit             op;
      logic [15:0]    addr;
      logic [7:0]     data;
      bit             typed;
      bus_result_type result;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_op = 1'b0;
   logic [15:0]           req_bus_address = '0;
   logic [7:0]            req_write_data = '0;
   logic                  rsp_valid;
   logic [1:0]            rsp_result_kind;
   logic [ROM_ADDR_W-1:0] rsp_rom_address;
   logic [7:0]            rsp_read_data;
   logic                  rsp_clock_latched;

   // Typed expectation that travels alongside a directed request.
   bit                    typed_valid = 1'b0;
   bus_result_type        typed_result = '0;

   // Mirror of the controller state, advanced as each request is taken.
   bit                    ram_enable = 1'b1;
   logic [ROM_BANK_W-1:0] rom_page = 7'd1;
   logic [SELECT_W-1:0]   ram_select = '0;
   bit                    latch_armed = 1'b0;
   bit                    latch_flag = 1'b0;
   logic [7:0]            rtc_regs [RTC_COUNT] = '{default: 8'h00};
   logic [7:0]            save_ram_mirror [RAM_BANKS * RAM_BANK_BYTES];
   bit                    ram_written [RAM_BANKS * RAM_BANK_BYTES];

   bus_result_type        pending_bus_results [$];
   int unsigned           error_count = 0;
   int unsigned           cycle_count = 0;
   directed_row_type      directed_rows [DIRECTED_COUNT];

   mbc3_bank_controller_top dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_bus_address   (req_bus_address),
      .req_write_data    (req_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_result_kind   (rsp_result_kind),
      .rsp_rom_address   (rsp_rom_address),
      .rsp_read_data     (rsp_read_data),
      .rsp_clock_latched (rsp_clock_latched)
   );

   // Clock with a period of 10 ns.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Cycle counter and the watchdog that stops a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("mbc3_bank_controller_top_tb failed");
      $finish;
   end

   // Applies one bus access to the mirrored state and returns the result it should give.
   function automatic bus_result_type apply_bus_access(bit op, logic [15:0] addr,
                                                       logic [7:0] data);
      bus_result_type r;
      int             idx;
      r = '0;
      r.kind = KIND_INVALID;
      if (!addr[15]) begin
         if (op == OP_WRITE) begin
            case (addr[14:13])
               REGION_ENABLE: begin
                  ram_enable = (data[3:0] == ENABLE_PATTERN);
               end
               REGION_ROM_BANK: begin
                  rom_page = (data[6:0] == '0) ? 7'd1 : data[6:0];
               end
               REGION_RAM_SEL: begin
                  ram_select = data[3:0];
               end
               default: begin
                  if (data == LATCH_ARM) begin
                     latch_armed = 1'b1;
                  end else if (data == LATCH_FIRE && latch_armed) begin
                     latch_flag  = ~latch_flag;
                     latch_armed = 1'b0;
                  end
               end
            endcase
            r.kind = KIND_WRITE;
         end else begin
            r.kind = KIND_ROM;
            // The lower half of ROM space is fixed to bank 0.
            r.rom_addr = addr[14] ? {rom_page, addr[13:0]} : {7'd0, addr[13:0]};
         end
      end else if (addr[15:13] == 3'b101) begin
         r.kind = (op == OP_WRITE) ? KIND_WRITE : KIND_READ;
         if (ram_enable) begin
            if (int'(ram_select) < RAM_BANKS) begin
               idx = int'(ram_select) * RAM_BANK_BYTES + int'(addr[12:0]);
               if (op == OP_WRITE) begin
                  save_ram_mirror[idx] = data;
                  ram_written[idx]     = 1'b1;
               end else begin
                  r.rd_data = save_ram_mirror[idx];
               end
            end else if (ram_select >= RTC_FIRST && ram_select <= RTC_LAST) begin
               idx = int'(ram_select - RTC_FIRST);
               if (op == OP_WRITE) begin
                  rtc_regs[idx] = data;
               end else begin
                  r.rd_data = rtc_regs[idx];
               end
            end
         end
      end
      r.latched = latch_flag;
      return r;
   endfunction

   // True when a read of this window address would hit cartridge RAM never written.
   function automatic bit reads_unwritten_ram(logic [15:0] addr);
      return ram_enable && int'(ram_select) < RAM_BANKS &&
             !ram_written[int'(ram_select) * RAM_BANK_BYTES + int'(addr[12:0])];
   endfunction

   // Reports one field of a result that differs from what was expected.
   task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         error_count++;
      end
   endtask

   // Result checking and request capture, both on the rising edge.
   always @(posedge clock) begin
      bus_result_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_bus_results.size() == 0) begin
               $display("%0t ns: result with no request pending, expected none, got kind %0h",
                        $time, rsp_result_kind);
               error_count++;
            end else begin
               want = pending_bus_results.pop_front();
               check_field("result_kind", 32'(want.kind), 32'(rsp_result_kind));
               check_field("rom_address", 32'(want.rom_addr), 32'(rsp_rom_address));
               check_field("read_data", 32'(want.rd_data), 32'(rsp_read_data));
               check_field("clock_latched", 32'(want.latched), 32'(rsp_clock_latched));
            end
         end
         if (start && !busy) begin
            want = apply_bus_access(req_op, req_bus_address, req_write_data);
            if (typed_valid) begin
               want = typed_result;
            end
            pending_bus_results.push_back(want);
         end
      end
   end

   // Drives one request from a falling edge and returns at the falling edge after it is taken.
   // With idle_odds non-zero, an idle gap with start low comes first with a chance of one in idle_odds.
   task automatic issue_request(bit op, logic [15:0] addr, logic [7:0] data,
                                bit typed, bus_result_type result, int unsigned idle_odds);
      int unsigned gap;
      if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
         gap = $urandom_range(1, 11);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_op          <= op;
      req_bus_address <= addr;
      req_write_data  <= data;
      typed_valid     <= typed;
      typed_result    <= result;
      start           <= 1'b1;
      do begin
         @(posedge clock);
      end while (busy);
      @(negedge clock);
   endtask

   // Picks one random bus access, weighted towards well-formed cartridge traffic.
   task automatic pick_random_access(output bit op, output logic [15:0] addr,
                                     output logic [7:0] data);
      int unsigned pick;
      logic [12:0] offset;
      pick = $urandom_range(0, 99);
      op   = bit'($urandom_range(0, 1));
      data = 8'($urandom_range(0, 255));
      if (pick < 20) begin
         // Control register writes with mostly meaningful data.
         op   = OP_WRITE;
         addr = 16'($urandom_range(0, 16'h7FFF));
         case (addr[14:13])
            REGION_ENABLE: begin
               if ($urandom_range(0, 3) != 0) data[3:0] = ENABLE_PATTERN;
            end
            REGION_RAM_SEL: begin
               if ($urandom_range(0, 4) != 0) begin
                  data[3:0] = ($urandom_range(0, 1) != 0) ? 4'($urandom_range(0, RAM_BANKS - 1))
                              : 4'($urandom_range(int'(RTC_FIRST), int'(RTC_LAST)));
               end
            end
            REGION_LATCH: begin
               case ($urandom_range(0, 9))
                  0, 1, 2, 3:    data = LATCH_ARM;
                  4, 5, 6, 7, 8: data = LATCH_FIRE;
                  default:       ;
               endcase
            end
            default: ;
         endcase
      end else if (pick < 50) begin
         // ROM fetches from both halves of ROM space.
         op   = OP_READ;
         addr = 16'($urandom_range(0, 16'h7FFF));
      end else if (pick < 90) begin
         // RAM window traffic, mostly on a few hot offsets so that reads find data.
         case ($urandom_range(0, 3))
            0:       offset = 13'($urandom_range(0, 8191));
            1:       offset = 13'h1FFF - 13'($urandom_range(0, 15));
            default: offset = 13'($urandom_range(0, 15));
         endcase
         addr = {3'b101, offset};
         if (op == OP_READ && reads_unwritten_ram(addr)) begin
            op = OP_WRITE;
         end
      end else begin
         // Unmapped address space.
         addr = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(16'h8000, 16'h9FFF))
                : 16'($urandom_range(16'hC000, 16'hFFFF));
      end
   endtask

   // Stimulus sequence and end of run.
   initial begin
      int unsigned idle_odds;
      bit          op;
      logic [15:0] addr;
      logic [7:0]  data;

      // Extremes, every region, the bank 0 remap, the latch sequence and a disabled window.
      directed_rows = '{
         '{OP_READ,  16'h0000, 8'h00, 1'b1, {KIND_ROM,     21'h000000, 8'h00, 1'b0}},
         '{OP_READ,  16'h3FFF, 8'h00, 1'b1, {KIND_ROM,     21'h003FFF, 8'h00, 1'b0}},
         '{OP_READ,  16'h7FFF, 8'h00, 1'b1, {KIND_ROM,     21'h007FFF, 8'h00, 1'b0}},
         '{OP_READ,  16'h8000, 8'h00, 1'b1, {KIND_INVALID, 21'h000000, 8'h00, 1'b0}},
         '{OP_WRITE, 16'hFFFF, 8'hFF, 1'b1, {KIND_INVALID, 21'h000000, 8'h00, 1'b0}},
         '{OP_WRITE, 16'h9FFF, 8'h00, 1'b1, {KIND_INVALID, 21'h000000, 8'h00, 1'b0}},
         '{OP_WRITE, 16'h3FFF, 8'hFF, 1'b1, {KIND_WRITE,   21'h000000, 8'h00, 1'b0}},
         '{OP_READ,  16'h7FFF, 8'h00, 1'b1, {KIND_ROM,     21'h1FFFFF, 8'h00, 1'b0}},
         '{OP_WRITE, 16'h2000, 8'h80, 1'b0, '0},
         '{OP_READ,  16'h4000, 8'hFF, 1'b0, '0},
         '{OP_WRITE, 16'hA000, 8'hFF, 1'b1, {KIND_WRITE,   21'h000000, 8'h00, 1'b0}},
         '{OP_READ,  16'hA000, 8'h00, 1'b1, {KIND_READ,    21'h000000, 8'hFF, 1'b0}},
         '{OP_WRITE, 16'h4000, 8'h03, 1'b0, '0},
         '{OP_WRITE, 16'hBFFF, 8'h00, 1'b0, '0},
         '{OP_READ,  16'hBFFF, 8'h00, 1'b0, '0},
         '{OP_WRITE, 16'h5FFF, 8'h0C, 1'b0, '0},
         '{OP_WRITE, 16'hA123, 8'hA5, 1'b0, '0},
         '{OP_READ,  16'hBFFE, 8'h00, 1'b0, '0},
         '{OP_WRITE, 16'h4000, 8'h0D, 1'b0, '0},
         '{OP_READ,  16'hA000, 8'h00, 1'b0, '0},
         '{OP_WRITE, 16'h6000, 8'h01, 1'b0, '0},
         '{OP_WRITE, 16'h7FFF, 8'h00, 1'b0, '0},
         '{OP_WRITE, 16'h6000, 8'h01, 1'b1, {KIND_WRITE,   21'h000000, 8'h00, 1'b1}},
         '{OP_WRITE, 16'h1FFF, 8'h00, 1'b0, '0},
         '{OP_READ,  16'hA000, 8'h00, 1'b0, '0},
         '{OP_WRITE, 16'h0000, 8'hFA, 1'b0, '0}
      };

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         issue_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].data,
                       directed_rows[i].typed, directed_rows[i].result, 4);
      end

      // Random requests; the idle pattern changes every hundred and stops for the tail.
      idle_odds = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 100 == 0) begin
            case ($urandom_range(0, 2))
               0:       idle_odds = 0;
               1:       idle_odds = 2;
               default: idle_odds = 6;
            endcase
         end
         if (i >= RANDOM_ITEMS - QUIET_TAIL) begin
            idle_odds = 0;
         end
         pick_random_access(op, addr, data);
         issue_request(op, addr, data, 1'b0, '0, idle_odds);
      end
      start <= 1'b0;

      // Let the last results arrive, then keep watching for stray results before the verdict.
      while (pending_bus_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (error_count == 0) begin
         $display("mbc3_bank_controller_top_tb passed");
      end else begin
         $display("mbc3_bank_controller_top_tb failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/mbc3_pkg.sv
sv/mbc3_ram.sv
sv/mbc3_ctrl.sv
sv/mbc3_bank_controller_top.sv
test/mbc3_bank_controller_top_tb.sv
